[src/htlp_pkg.sv]
// shared types, codes and helpers for the ttl hash table
package htlp_pkg;

	typedef enum logic [1:0] {
		FN_GET  = 2'd0,
		FN_SET  = 2'd1,
		FN_TICK = 2'd2,
		FN_NONE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_KEY_LONG  = 3'd1,
		ST_VAL_LONG  = 3'd2,
		ST_TTL_LOW   = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	localparam logic REG_KEY_LIMIT = 1'b0;
	localparam logic REG_VAL_LIMIT = 1'b1;

	typedef struct packed {
		logic        expired;
		logic [63:0] key;
		logic [3:0]  klen;
		logic [63:0] val;
		logic [3:0]  vlen;
		logic [15:0] ticks;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic load;
		logic start;
		logic scan;
		logic tick;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_op;
		logic tick_op;
		logic hit_now;
		logic scan_end;
		logic out_free;
	} sts_t;

	function automatic logic [63:0] byte_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			m[8*b +: 8] = (4'(b) < len) ? 8'hff : 8'h00;
		end
		return m;
	endfunction

endpackage

[src/htlp_ram.sv]
// generic simple dual-port ram with registered read
module htlp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[src/htlp_ctrl.sv]
// sequencing state machine for the ttl hash table
module htlp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  htlp_pkg::sts_t sts,
	output htlp_pkg::cmd_t cmd
);
	import htlp_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_SCAN   = 5'b00100,
		S_TICK   = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.tick_op) begin
					cmd.start = 1'b1;
					state_d   = S_TICK;
				end else if (sts.scan_op) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit_now || sts.scan_end) begin
					state_d = S_DONE;
				end
			end
			S_TICK: begin
				cmd.tick = 1'b1;
				if (sts.scan_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

[src/htlp_dp.sv]
// datapath: word registers, entry ram, scan counters and result register
module htlp_dp #(
	parameter int TABLE_ENTRIES = 256,
	parameter int KEY_BYTES     = 8,
	parameter int VALUE_BYTES   = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  htlp_pkg::cmd_t cmd,
	output htlp_pkg::sts_t sts,
	input  logic [3:0]     key_limit,
	input  logic [3:0]     value_limit,
	input  logic [1:0]     func,
	input  logic [63:0]    key_bytes,
	input  logic [3:0]     key_length,
	input  logic [63:0]    value_bytes,
	input  logic [3:0]     value_length,
	input  logic [15:0]    time_to_live,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [2:0]     status,
	output logic [63:0]    out_value,
	output logic [3:0]     out_value_length
);
	import htlp_pkg::*;

	localparam int IDXW = $clog2(TABLE_ENTRIES);
	localparam int CNTW = IDXW + 1;

	logic [1:0]  func_q;
	logic [63:0] key_q, val_q;
	logic [3:0]  klen_q, vlen_q;
	logic [15:0] ttl_q;

	logic [CNTW-1:0] fill_q, addr_q;
	logic            rv_q, hit_q;
	logic [IDXW-1:0] ridx_q;

	logic                out_valid_q;
	logic [2:0]          status_q;
	logic [63:0]         oval_q;
	logic [3:0]          olen_q;

	logic [ENTRY_W-1:0] rdata, wdata_raw;
	entry_t             rd, wd;
	logic               we, re;
	logic [IDXW-1:0]    waddr;

	logic key_bad, val_bad, full, match, issue, is_get, is_set;
	logic [2:0]  res_status;
	logic [63:0] res_val;
	logic [3:0]  res_len;

	assign rd = entry_t'(rdata);

	assign is_get  = (func_q == FN_GET);
	assign is_set  = (func_q == FN_SET);
	assign key_bad = (klen_q >= key_limit) || (klen_q > 4'(KEY_BYTES));
	assign val_bad = (vlen_q >= value_limit) || (vlen_q > 4'(VALUE_BYTES));
	assign full    = (fill_q == CNTW'(TABLE_ENTRIES));

	assign match = rv_q && !rd.expired && (rd.klen == klen_q) && (rd.key == key_q);
	assign issue = (cmd.scan && !match) || cmd.tick;
	assign re    = issue && (addr_q < fill_q);

	assign sts.scan_op  = !key_bad && (is_get || (is_set && !val_bad && (ttl_q != 16'd0)));
	assign sts.tick_op  = (func_q == FN_TICK);
	assign sts.hit_now  = cmd.scan && match;
	assign sts.scan_end = !rv_q && (addr_q >= fill_q);
	assign sts.out_free = !out_valid_q || !out_stall;

	always_comb begin
		res_status = ST_OK;
		res_val    = '0;
		res_len    = '0;
		we         = 1'b0;
		waddr      = ridx_q;
		wd         = rd;
		if (cmd.tick) begin
			if (rv_q && !rd.expired) begin
				we = 1'b1;
				if (rd.ticks == 16'd0) begin
					wd.expired = 1'b1;
				end else begin
					wd.ticks = rd.ticks - 16'd1;
				end
			end
		end else if (cmd.finish) begin
			unique case (func_q)
				FN_GET: begin
					if (key_bad) begin
						res_status = ST_KEY_LONG;
					end else if (hit_q) begin
						res_val = rd.val;
						res_len = rd.vlen;
					end else begin
						res_status = ST_NOT_FOUND;
					end
				end
				FN_SET: begin
					wd.expired = 1'b0;
					wd.key     = key_q;
					wd.klen    = klen_q;
					wd.val     = val_q;
					wd.vlen    = vlen_q;
					wd.ticks   = ttl_q;
					if (key_bad) begin
						res_status = ST_KEY_LONG;
					end else if (val_bad) begin
						res_status = ST_VAL_LONG;
					end else if (ttl_q == 16'd0) begin
						res_status = ST_TTL_LOW;
					end else if (hit_q || !full) begin
						we      = 1'b1;
						waddr   = hit_q ? ridx_q : fill_q[IDXW-1:0];
						res_val = val_q;
						res_len = vlen_q;
					end else begin
						res_status = ST_FULL;
					end
				end
				default: begin
					res_status = ST_OK;
				end
			endcase
		end
	end

	assign wdata_raw = wd;

	htlp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata_raw),
		.re   (re),
		.raddr(addr_q[IDXW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			key_q  <= key_bytes & byte_mask(key_length);
			klen_q <= key_length;
			val_q  <= value_bytes & byte_mask(value_length);
			vlen_q <= value_length;
			ttl_q  <= time_to_live;
		end
		if (re) begin
			ridx_q <= addr_q[IDXW-1:0];
		end
		if (cmd.finish) begin
			status_q <= res_status;
			oval_q   <= res_val;
			olen_q   <= res_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			addr_q      <= '0;
			rv_q        <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				addr_q <= '0;
				rv_q   <= 1'b0;
				hit_q  <= 1'b0;
			end else if (cmd.scan || cmd.tick) begin
				rv_q <= re;
				if (re) begin
					addr_q <= addr_q + CNTW'(1);
				end
				if (sts.hit_now) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.finish && is_set && we && !hit_q) begin
				fill_q <= fill_q + CNTW'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign out_value        = oval_q;
	assign out_value_length = olen_q;
endmodule

[src/ttl_hash_table_linear_probe.sv]
// top level of the ttl hash table: config registers, controller and datapath
//
// Key-value cache with time to live in an open-addressed, linearly probed table.
// Input channel (in_valid / in_stall) carries one word: func, key, value, ttl.
// Output channel (out_valid / out_stall) carries one result word per input word.
// Config port: APB-style, key_limit at address 0, value_limit at address 4.
// Cells fill in order from cell zero and never free, so a fill count stands
// in for the busy flags and no clearing pass is needed after reset.
// A rejected or unused word goes from decode straight to the result register.
// A get or set probes one cell per cycle from the entry ram's read port,
// over the filled cells in order, stopping early on a hit.
// A tick reads every filled cell and writes back each one not yet expired.
// One word is worked on at a time; in_stall is high until it finishes.
// A finished result waits in the output register while out_stall is high,
// and the next word is accepted and worked on meanwhile.
// Reset empties the table and sets both limits to 9.
module ttl_hash_table_linear_probe #(
	parameter int TABLE_ENTRIES = 256,
	parameter int KEY_BYTES     = 8,
	parameter int VALUE_BYTES   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [63:0] key_bytes,
	input  logic [3:0]  key_length,
	input  logic [63:0] value_bytes,
	input  logic [3:0]  value_length,
	input  logic [15:0] time_to_live,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [63:0] out_value,
	output logic [3:0]  out_value_length
);
	import htlp_pkg::*;

	logic [3:0] key_limit_q, value_limit_q;
	cmd_t       cmd;
	sts_t       sts;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_VAL_LIMIT) ? {28'd0, value_limit_q} : {28'd0, key_limit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_limit_q   <= 4'd9;
			value_limit_q <= 4'd9;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_KEY_LIMIT) begin
				key_limit_q <= pwdata[3:0];
			end else begin
				value_limit_q <= pwdata[3:0];
			end
		end
	end

	htlp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	htlp_dp #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.KEY_BYTES    (KEY_BYTES),
		.VALUE_BYTES  (VALUE_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.key_limit       (key_limit_q),
		.value_limit     (value_limit_q),
		.func            (func),
		.key_bytes       (key_bytes),
		.key_length      (key_length),
		.value_bytes     (value_bytes),
		.value_length    (value_length),
		.time_to_live    (time_to_live),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.out_value       (out_value),
		.out_value_length(out_value_length)
	);
endmodule

[bench/tb_ttl_hash_table_linear_probe.sv]
// testbench for the ttl hash table: directed and random get, set, tick and no-op words checked against a predictor
`timescale 1ns / 100ps

import htlp_pkg::*;

class cache_scoreboard;
	localparam int CELLS = 256;
	bit        busy [CELLS];
	bit        dead [CELLS];
	bit [63:0] ckey [CELLS];
	bit [3:0]  cklen [CELLS];
	bit [63:0] cval [CELLS];
	bit [3:0]  cvlen [CELLS];
	bit [15:0] cticks [CELLS];
	bit [3:0]  key_lim;
	bit [3:0]  val_lim;
	bit [2:0]  want_status [$];
	bit [63:0] want_value [$];
	bit [3:0]  want_len [$];
	int        errors;

	function new();
		key_lim = 9;
		val_lim = 9;
		errors = 0;
	endfunction

	function bit [63:0] mask_bytes(bit [3:0] n);
		bit [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++)
			if (b < n)
				m[8*b +: 8] = 8'hff;
		return m;
	endfunction

	function int find_live(bit [63:0] k, bit [3:0] n);
		for (int i = 0; i < CELLS; i++)
			if (busy[i] && !dead[i] && cklen[i] == n && ckey[i] == k)
				return i;
		return -1;
	endfunction

	function void note_word(bit [1:0] fn, bit [63:0] kb, bit [3:0] kl, bit [63:0] vb,
			bit [3:0] vl, bit [15:0] ttl);
		bit        kbad;
		bit        vbad;
		bit [63:0] k;
		bit [63:0] v;
		bit [2:0]  st;
		bit [63:0] ov;
		bit [3:0]  ol;
		int        idx;
		kbad = kl >= key_lim || kl > 8;
		vbad = vl >= val_lim || vl > 8;
		k = kbad ? 64'd0 : kb & mask_bytes(kl);
		v = vbad ? 64'd0 : vb & mask_bytes(vl);
		st = ST_OK;
		ov = 0;
		ol = 0;
		if (fn == FN_GET) begin
			if (kbad) st = ST_KEY_LONG;
			else begin
				idx = find_live(k, kl);
				if (idx < 0) st = ST_NOT_FOUND;
				else begin
					ov = cval[idx];
					ol = cvlen[idx];
				end
			end
		end else if (fn == FN_SET) begin
			if (kbad) st = ST_KEY_LONG;
			else if (vbad) st = ST_VAL_LONG;
			else if (ttl == 0) st = ST_TTL_LOW;
			else begin
				idx = find_live(k, kl);
				if (idx < 0) begin
					for (int i = 0; i < CELLS && idx < 0; i++)
						if (!busy[i] && !dead[i])
							idx = i;
					if (idx >= 0) begin
						busy[idx] = 1;
						ckey[idx] = k;
						cklen[idx] = kl;
					end
				end
				if (idx < 0) st = ST_FULL;
				else begin
					cval[idx] = v;
					cvlen[idx] = vl;
					cticks[idx] = ttl;
					ov = v;
					ol = vl;
				end
			end
		end else if (fn == FN_TICK) begin
			for (int i = 0; i < CELLS; i++)
				if (busy[i] && !dead[i]) begin
					if (cticks[i] == 0) dead[i] = 1;
					else cticks[i] = cticks[i] - 1;
				end
		end
		want_status.push_back(st);
		want_value.push_back(ov);
		want_len.push_back(ol);
	endfunction

	task report(string what, longint got, longint exp);
		$display("result %s: got %0h expected %0h", what, got, exp);
		errors++;
	endtask

	task check_result(bit [2:0] st, bit [63:0] ov, bit [3:0] ol);
		bit [2:0]  es;
		bit [63:0] ev;
		bit [3:0]  el;
		if (want_status.size() == 0) begin
			report("unexpected word status", st, 0);
			return;
		end
		es = want_status.pop_front();
		ev = want_value.pop_front();
		el = want_len.pop_front();
		if (st !== es) report("status", st, es);
		if (ov !== ev) report("out_value", ov, ev);
		if (ol !== el) report("out_value_length", ol, el);
	endtask
endclass

module tb_ttl_hash_table_linear_probe;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  func = 0;
	logic [63:0] key_bytes = 0, value_bytes = 0;
	logic [3:0]  key_length = 0, value_length = 0;
	logic [15:0] time_to_live = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  status;
	logic [63:0] out_value;
	logic [3:0]  out_value_length;

	cache_scoreboard sb = new();
	bit          calm;
	logic [63:0] key_pool [16];

	ttl_hash_table_linear_probe u_top (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, out_value, out_value_length);

	always @(negedge clk)
		out_stall <= !calm && $urandom_range(99) < 34;

	task write_limit(logic [2:0] addr, logic [3:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= 32'(val);
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (addr == 0) sb.key_lim = val;
		else sb.val_lim = val;
	endtask

	task drain;
		in_valid <= 0;
		while (sb.want_status.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task send_word(logic [1:0] fn, logic [63:0] kb, logic [3:0] kl, logic [63:0] vb,
			logic [3:0] vl, logic [15:0] ttl);
		while (!calm && $urandom_range(99) < 34) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1; func <= fn; key_bytes <= kb; key_length <= kl;
		value_bytes <= vb; value_length <= vl; time_to_live <= ttl;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_word(fn, kb, kl, vb, vl, ttl);
		@(negedge clk);
	endtask

	task random_word;
		logic [1:0]  fn;
		logic [63:0] kb;
		int          r;
		r = $urandom_range(99);
		fn = r < 45 ? FN_SET : r < 85 ? FN_GET : r < 96 ? FN_TICK : FN_NONE;
		kb = ($urandom_range(9) < 8) ? key_pool[$urandom_range(15)]
			: {$urandom, $urandom};
		send_word(fn, kb | ({$urandom, $urandom} & {64{$urandom_range(3) == 0}}),
			($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8)),
			{$urandom, $urandom},
			($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8)),
			($urandom_range(29) == 0) ? 16'd0 :
			($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6)));
	endtask

	initial begin
		calm = 0;
		for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// directed
		send_word(FN_GET, '1, 8, 0, 0, 0);
		send_word(FN_SET, '1, 8, '1, 8, 16'hffff);
		send_word(FN_GET, '1, 8, 0, 0, 0);
		send_word(FN_SET, 64'h12, 0, '1, 0, 1);
		send_word(FN_GET, 64'hff, 0, 0, 0, 0);
		send_word(FN_SET, 64'hab, 9, 0, 0, 1);
		send_word(FN_SET, 64'hab, 15, 0, 15, 0);
		send_word(FN_SET, 64'hab, 1, 0, 9, 1);
		send_word(FN_SET, 64'hab, 1, 0, 1, 0);
		send_word(FN_SET, 64'hffab, 1, 64'h77, 1, 1);
		send_word(FN_GET, 64'h00ab, 1, 0, 0, 0);
		send_word(FN_TICK, 0, 0, 0, 0, 0);
		send_word(FN_GET, 64'hab, 1, 0, 0, 0);
		send_word(FN_TICK, 0, 0, 0, 0, 0);
		send_word(FN_GET, 64'hab, 1, 0, 0, 0);
		send_word(FN_SET, 64'hab, 1, 64'h55, 2, 3);
		send_word(FN_NONE, '1, 15, '1, 15, '1);
		drain();
		write_limit(0, 1);
		write_limit(4, 1);
		send_word(FN_SET, 0, 1, 0, 0, 1);
		send_word(FN_SET, 0, 0, 64'h1, 1, 1);
		send_word(FN_SET, 0, 0, 0, 0, 2);
		send_word(FN_GET, 0, 0, 0, 0, 0);
		drain();
		write_limit(0, 15);
		write_limit(4, 15);
		// random phases with several limit settings
		for (int p = 0; p < 6; p++) begin
			calm = (p == 2);
			for (int i = 0; i < 260; i++) begin
				random_word();
				if (i == 150 && p == 1) drain();
			end
			drain();
			write_limit(0, 4'($urandom_range(1, 9)));
			write_limit(4, 4'($urandom_range(1, 9)));
		end
		// fill the table to reach the full status
		write_limit(0, 9);
		write_limit(4, 9);
		calm = 1;
		for (int i = 0; i < 262; i++)
			send_word(FN_SET, 64'(i) << 16 | 64'hbeef, 8, 64'(i), 8, 16'hffff);
		send_word(FN_GET, 64'hbeef, 8, 0, 0, 0);
		drain();
		if (sb.errors == 0)
			$display("ttl_hash_table_linear_probe: match");
		else
			$display("ttl_hash_table_linear_probe: mismatch");
		$finish;
	end

	initial begin
		#20000000;
		$display("ttl_hash_table_linear_probe: mismatch");
		$finish;
	end
endmodule
